// ----- hdl/mac_address_slot_table_assert.svh -----
// ----------------------------------------------------------------------------
// MAC address slot table assertion macros
// Shared property forms for the slot table checks.
// ----------------------------------------------------------------------------
`ifndef MAC_ADDRESS_SLOT_TABLE_ASSERT_SVH
`define MAC_ADDRESS_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MAST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MAST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mast_pkg.sv -----
// ----------------------------------------------------------------------------
// mast_pkg
// Constants, codes and controller/datapath interface types of the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package mast_pkg;

    // Table size default
    localparam int SLOTS_DEFAULT = 8;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

    // Reserved addresses: every byte 0x00 or every byte 0xff
    localparam logic [ADDR_W-1:0] ADDR_ZERO = {6{8'h00}};
    localparam logic [ADDR_W-1:0] ADDR_ONES = {6{8'hff}};

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch request
        logic idx_clr;   // scan index back to zero
        logic idx_inc;   // advance scan index
        logic rd_issue;  // read one slot for the match/empty scan
        logic reject;    // finish a request without scanning
        logic apply;     // decide and update the table
        logic top_step;  // one step of the highest-slot scan
        logic load_out;  // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic bad;       // reserved address or request kind
        logic idx_last;  // scan index at last slot
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/mast_datapath.sv -----
// ----------------------------------------------------------------------------
// mast_datapath
// Slot memory, valid bits, scan registers, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mast_datapath #(
    parameter int SLOTS = mast_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mast_pkg::t_cmd                   i_cmd,
    output      mast_pkg::t_sts                   o_sts,
    input  wire logic [mast_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [mast_pkg::ADDR_W-1:0]      i_mac_address,
    input  wire logic                             i_out_ready,
    output      logic                             o_out_valid,
    output      logic [mast_pkg::STATUS_W-1:0]    o_status,
    output      logic [mast_pkg::SLOT_W-1:0]      o_slot,
    output      logic [mast_pkg::COUNT_W-1:0]     o_entry_count,
    output      logic [mast_pkg::SLOT_W-1:0]      o_highest_slot
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = mast_pkg::SLOT_W;
    localparam int KW = mast_pkg::COUNT_W;

    // Request registers
    logic [mast_pkg::REQ_W-1:0]    r_req;
    logic [mast_pkg::ADDR_W-1:0]   r_addr;

    // Table storage
    logic [mast_pkg::ADDR_W-1:0]   r_mem [SLOTS];
    logic                          r_valid [SLOTS];

    // Scan registers
    logic [IW-1:0]                 r_idx;
    logic                          r_rd_en;
    logic [mast_pkg::ADDR_W-1:0]   r_rd_data;
    logic                          r_rd_vld;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_found;
    logic [IW-1:0]                 r_match;
    logic                          r_has_empty;
    logic [IW-1:0]                 r_empty;

    // Table summary and result
    logic [CW-1:0]                 r_count;
    logic [IW-1:0]                 r_top;
    logic [mast_pkg::STATUS_W-1:0] r_status;
    logic [IW-1:0]                 r_slot;
    logic                          r_out_valid;

    logic                          bad_addr;
    logic                          hit;
    logic [mast_pkg::STATUS_W-1:0] n_status;
    logic [IW-1:0]                 n_slot;
    logic                          add_ok;
    logic                          del_ok;

    // Status to controller
    assign bad_addr         = (r_addr == mast_pkg::ADDR_ZERO) || (r_addr == mast_pkg::ADDR_ONES);
    assign o_sts.bad        = bad_addr || (r_req == mast_pkg::REQ_RSVD);
    assign o_sts.idx_last   = (r_idx == IW'(SLOTS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Compare of the slot read in the previous cycle
    assign hit = r_rd_en && r_rd_vld && (r_rd_data == r_addr);

    // Decision on the scan results
    always_comb begin
        n_status = mast_pkg::ST_NOTFOUND;
        n_slot   = '0;
        add_ok   = 1'b0;
        del_ok   = 1'b0;
        unique case (r_req)
            mast_pkg::REQ_ADD: begin
                priority if (r_count >= CW'(SLOTS)) begin
                    n_status = mast_pkg::ST_FULL;
                end else if (r_found) begin
                    n_status = mast_pkg::ST_DUP;
                end else if (!r_has_empty) begin
                    n_status = mast_pkg::ST_FULL;
                end else begin
                    n_status = mast_pkg::ST_OK;
                    n_slot   = r_empty;
                    add_ok   = 1'b1;
                end
            end
            mast_pkg::REQ_DELETE: begin
                if (r_found) begin
                    n_status = mast_pkg::ST_OK;
                    n_slot   = r_match;
                    del_ok   = 1'b1;
                end
            end
            mast_pkg::REQ_LOOKUP: begin
                if (r_found) begin
                    n_status = mast_pkg::ST_OK;
                    n_slot   = r_match;
                end
            end
            default: begin
                n_status = mast_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_addr <= i_mac_address;
        end
    end

    // Slot memory: one write at decide, one read per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && add_ok) begin
            r_mem[r_empty] <= r_addr;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_cmd.apply) begin
            if (add_ok) begin
                r_valid[r_empty] <= 1'b1;
            end else if (del_ok) begin
                r_valid[r_match] <= 1'b0;
            end
        end
    end

    // Read pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_vld <= r_valid[r_idx];
            r_rd_idx <= r_idx;
        end
    end

    // Scan index and read strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_cmd.rd_issue;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // First match and first empty slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (i_cmd.capture) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else begin
            if (hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (r_rd_en && !r_rd_vld && !r_has_empty) begin
                r_has_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit && !r_found) begin
            r_match <= r_rd_idx;
        end
        if (r_rd_en && !r_rd_vld && !r_has_empty) begin
            r_empty <= r_rd_idx;
        end
    end

    // Occupied count and highest occupied slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
        end else begin
            if (i_cmd.apply) begin
                r_top <= '0;
                if (add_ok) begin
                    r_count <= r_count + CW'(1);
                end else if (del_ok && (r_count != '0)) begin
                    r_count <= r_count - CW'(1);
                end
            end else if (i_cmd.top_step && r_valid[r_idx]) begin
                r_top <= r_idx;
            end
        end
    end

    // Request outcome
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status <= n_status;
            r_slot   <= n_slot;
        end else if (i_cmd.reject) begin
            r_status <= bad_addr ? mast_pkg::ST_INVALID : mast_pkg::ST_NOTFOUND;
            r_slot   <= '0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status       <= r_status;
            o_slot         <= SW'(r_slot);
            o_entry_count  <= KW'(r_count);
            o_highest_slot <= SW'(r_top);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- hdl/mast_ctrl.sv -----
// ----------------------------------------------------------------------------
// mast_ctrl
// Sequencer: capture, match/empty scan, update, highest-slot scan, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mast_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire mast_pkg::t_sts i_sts,
    output      mast_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_TOP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DRAIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            // last compare lands here
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.apply = 1'b1;
                n_state     = S_TOP;
            end
            S_TOP: begin
                o_cmd.top_step = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mac_address_slot_table.sv -----
// ----------------------------------------------------------------------------
// mac_address_slot_table
// Flow: a request passes a match/empty scan and a highest-slot scan, each
//   reading one slot per cycle; a reserved address or request kind skips both.
// A new request is taken only after the last result has been loaded into the
//   result register; a held result stalls it.
// Reset: synchronous active low; all slots empty, count and highest slot zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_address_slot_table #(
    parameter int SLOTS = mast_pkg::SLOTS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // [47:0] mac_address
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    // result side
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [15:0] o_m_tdata    // [2:0] status, [5:3] slot,
                                          // [9:6] entry_count,
                                          // [12:10] highest_slot, [15:13] zero
);

    `include "mac_address_slot_table_assert.svh"

    mast_pkg::t_cmd                cmd;
    mast_pkg::t_sts                sts;
    logic [mast_pkg::STATUS_W-1:0] status;
    logic [mast_pkg::SLOT_W-1:0]   slot;
    logic [mast_pkg::COUNT_W-1:0]  entry_count;
    logic [mast_pkg::SLOT_W-1:0]   highest_slot;

    // Sequencer
    mast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table and result datapath
    mast_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_s_tuser),
        .i_mac_address  (i_s_tdata),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_status       (status),
        .o_slot         (slot),
        .o_entry_count  (entry_count),
        .o_highest_slot (highest_slot)
    );

    // Result packing
    assign o_m_tdata = {3'b000, highest_slot, entry_count, slot, status};

    // Controller issues at most one phase command per cycle
    `MAST_ASSERT_IMP(a_cmd_exclusive, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.capture, cmd.rd_issue, cmd.reject, cmd.apply, cmd.top_step,
                  cmd.load_out}),
        "mast: overlapping phase commands")

    // A failed request never reports a slot
    `MAST_ASSERT_IMP(a_fail_slot_zero, i_clk, i_rst_n,
        o_m_tvalid && (status != mast_pkg::ST_OK), slot == '0,
        "mast: slot set on failed request")

    // No result can appear the cycle right after a request is taken
    `MAST_ASSERT_NXT(a_min_latency, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        !$rose(o_m_tvalid), "mast: result too early")

endmodule

`default_nettype wire

// ----- bench/slot_table_checker.sv -----
// ----------------------------------------------------------------------------
// slot_table_checker
// Watches the request and result streams of the MAC address slot table. It
// keeps its own copy of the table, works out the result of every accepted
// request, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module slot_table_checker #(
    parameter int SLOTS = mast_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,    // [47:0] mac_address
    input  logic [1:0]  i_s_tuser,    // [1:0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [2:0] status, [5:3] slot, [9:6] entry_count,
                                      // [12:10] highest_slot, [15:13] zero
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mast_pkg::STATUS_W-1:0] status;
        logic [mast_pkg::SLOT_W-1:0]   slot;
        logic [mast_pkg::COUNT_W-1:0]  entry_count;
        logic [mast_pkg::SLOT_W-1:0]   highest_slot;
    } t_table_result;

    // Shadow table
    logic [mast_pkg::ADDR_W-1:0] shadow_addr [SLOTS];
    int                          shadow_count;
    t_table_result               expected_results [$];

    // Apply one request to the shadow table and return its result
    task automatic apply_table_request(input logic [mast_pkg::REQ_W-1:0] kind,
                                       input logic [mast_pkg::ADDR_W-1:0] addr,
                                       output t_table_result res);
        int hit;
        int free_slot;
        int top_used;
        hit       = -1;
        free_slot = -1;
        top_used  = 0;
        res.status = mast_pkg::ST_OK;
        res.slot   = '0;
        // lowest matching slot and lowest empty slot
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (shadow_addr[i] == addr) hit = i;
            if (shadow_addr[i] == mast_pkg::ADDR_ZERO) free_slot = i;
        end
        if (addr == mast_pkg::ADDR_ZERO || addr == mast_pkg::ADDR_ONES) begin
            res.status = mast_pkg::ST_INVALID;
        end else begin
            case (kind)
                mast_pkg::REQ_ADD: begin
                    // full wins over duplicate
                    if (shadow_count >= SLOTS) begin
                        res.status = mast_pkg::ST_FULL;
                    end else if (hit >= 0) begin
                        res.status = mast_pkg::ST_DUP;
                    end else if (free_slot < 0) begin
                        res.status = mast_pkg::ST_FULL;
                    end else begin
                        shadow_addr[free_slot] = addr;
                        shadow_count++;
                        res.slot = mast_pkg::SLOT_W'(free_slot);
                    end
                end
                mast_pkg::REQ_DELETE: begin
                    if (hit < 0) begin
                        res.status = mast_pkg::ST_NOTFOUND;
                    end else begin
                        shadow_addr[hit] = mast_pkg::ADDR_ZERO;
                        if (shadow_count > 0) shadow_count--;
                        res.slot = mast_pkg::SLOT_W'(hit);
                    end
                end
                mast_pkg::REQ_LOOKUP: begin
                    if (hit < 0) res.status = mast_pkg::ST_NOTFOUND;
                    else         res.slot = mast_pkg::SLOT_W'(hit);
                end
                default: begin
                    res.status = mast_pkg::ST_NOTFOUND;
                end
            endcase
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_addr[i] != mast_pkg::ADDR_ZERO) top_used = i;
        end
        res.entry_count  = mast_pkg::COUNT_W'(shadow_count);
        res.highest_slot = mast_pkg::SLOT_W'(top_used);
    endtask

    task automatic check_field(input string label, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, label, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Track both streams
    always @(posedge i_clk) begin
        t_table_result exp_res;
        t_table_result act_res;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) shadow_addr[i] = mast_pkg::ADDR_ZERO;
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // result side
            if (i_m_tvalid && i_m_tready) begin
                act_res.status       = i_m_tdata[2:0];
                act_res.slot         = i_m_tdata[5:3];
                act_res.entry_count  = i_m_tdata[9:6];
                act_res.highest_slot = i_m_tdata[12:10];
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("status", exp_res.status, act_res.status);
                    check_field("slot", exp_res.slot, act_res.slot);
                    check_field("entry_count", exp_res.entry_count, act_res.entry_count);
                    check_field("highest_slot", exp_res.highest_slot,
                                act_res.highest_slot);
                end
            end
            // request side
            if (i_s_tvalid && i_s_tready) begin
                apply_table_request(i_s_tuser, i_s_tdata, exp_res);
                expected_results.push_back(exp_res);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the MAC address slot table: a directed pass over reserved
// addresses, request kinds, a full table and slot reuse, then random
// requests drawn mostly from a small address pool so that hits, duplicates
// and full-table cases keep coming. Both sides idle at random, and the
// result side holds off once for a long stretch to back up the requests.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE    = 12;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;    // [47:0] mac_address
    logic [1:0]  i_s_tuser;    // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // [2:0] status, [5:3] slot, [9:6] entry_count,
                               // [12:10] highest_slot, [15:13] zero

    int fail_count;
    int pending;
    int send_idle_pct  = 22;
    int ready_idle_pct = 22;
    bit hold_results   = 1'b0;
    int quiet_cycles   = 0;

    logic [mast_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    mac_address_slot_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    slot_table_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random usable address, every bit free
    function automatic logic [mast_pkg::ADDR_W-1:0] random_address();
        logic [63:0] word;
        word = {$urandom, $urandom};
        while (word[47:0] == mast_pkg::ADDR_ZERO || word[47:0] == mast_pkg::ADDR_ONES)
            word = {$urandom, $urandom};
        return word[47:0];
    endfunction

    // Offer one request and hold it until accepted
    task automatic issue_request(input logic [mast_pkg::REQ_W-1:0] kind,
                                 input logic [mast_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Result side: random ready, with one long hold-off on demand
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                hold_results = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(99) >= ready_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL mac_address_slot_table");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial begin
        int pick;
        int slot_pick;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;

        addr_pool[0] = 48'h0000_0000_0001;
        addr_pool[1] = 48'hFFFF_FFFF_FFFE;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = random_address();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // misses on an empty table
        issue_request(mast_pkg::REQ_LOOKUP, addr_pool[0]);
        issue_request(mast_pkg::REQ_DELETE, addr_pool[1]);
        // reserved addresses on every kind, reserved kind
        issue_request(mast_pkg::REQ_ADD, mast_pkg::ADDR_ZERO);
        issue_request(mast_pkg::REQ_ADD, mast_pkg::ADDR_ONES);
        issue_request(mast_pkg::REQ_DELETE, mast_pkg::ADDR_ZERO);
        issue_request(mast_pkg::REQ_LOOKUP, mast_pkg::ADDR_ONES);
        issue_request(mast_pkg::REQ_RSVD, mast_pkg::ADDR_ZERO);
        issue_request(mast_pkg::REQ_RSVD, addr_pool[2]);
        // fill every slot
        for (int i = 0; i < 8; i++) issue_request(mast_pkg::REQ_ADD, addr_pool[i]);
        // full table, with and without a duplicate
        issue_request(mast_pkg::REQ_ADD, addr_pool[0]);
        issue_request(mast_pkg::REQ_ADD, addr_pool[8]);
        issue_request(mast_pkg::REQ_LOOKUP, addr_pool[3]);
        // free the top and the bottom slot, then reuse the lowest
        issue_request(mast_pkg::REQ_DELETE, addr_pool[7]);
        issue_request(mast_pkg::REQ_DELETE, addr_pool[0]);
        issue_request(mast_pkg::REQ_ADD, addr_pool[8]);
        issue_request(mast_pkg::REQ_ADD, addr_pool[8]);
        issue_request(mast_pkg::REQ_DELETE, addr_pool[3]);
        issue_request(mast_pkg::REQ_LOOKUP, addr_pool[3]);

        // random requests, mostly on the pool
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n > 0 && n % 125 == 0) begin
                // empty the table and draw a new pool
                for (int i = 0; i < POOL_SIZE; i++)
                    issue_request(mast_pkg::REQ_DELETE, addr_pool[i]);
                for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_address();
            end
            if (n == 100) hold_results = 1'b1;
            if (n >= 300 && n < 400) begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end else begin
                send_idle_pct  = 22;
                ready_idle_pct = 22;
            end
            pick      = $urandom_range(99);
            slot_pick = $urandom_range(POOL_SIZE - 1);
            if (pick < 35)
                issue_request(mast_pkg::REQ_ADD, addr_pool[slot_pick]);
            else if (pick < 55)
                issue_request(mast_pkg::REQ_DELETE, addr_pool[slot_pick]);
            else if (pick < 75)
                issue_request(mast_pkg::REQ_LOOKUP, addr_pool[slot_pick]);
            else if (pick < 85)
                issue_request(mast_pkg::REQ_W'($urandom_range(3, 1)), random_address());
            else if (pick < 92)
                issue_request(mast_pkg::REQ_W'($urandom_range(3)),
                              ($urandom_range(1) == 1) ? mast_pkg::ADDR_ONES
                                                       : mast_pkg::ADDR_ZERO);
            else
                issue_request(mast_pkg::REQ_RSVD, addr_pool[slot_pick]);
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        // let the last results drain
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS mac_address_slot_table");
        else
            $display("FAIL mac_address_slot_table");
        $finish;
    end

endmodule
